/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/wca_pkg.sv */
// Shared types and constants for the weighted centroid accumulator.
// No dependencies.
package wca_pkg;
   localparam int ENTRIES = 256;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SUM_W = 48;
   localparam int WSUM_W = 32;
   localparam int QUO_W = 17;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ACCUM = 2'd1;
   localparam logic [1:0] CMD_FINAL = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  entry;
      logic [15:0] alpha_in;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] weight;
   } req_type;

   typedef struct packed {
      logic [7:0]  entry_out;
      logic [15:0] alpha_out;
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [31:0] popularity;
      logic        has_members;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic clr_step;   // clear entry at clear counter
      logic rd;         // read entry
      logic add_wr;     // write accumulated sums
      logic div_step;   // one quotient bit
      logic rsp_load;   // form result
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic div_last;
   } sts_type;
endpackage

/* hdl/weighted_centroid_accumulator_core.sv */
// Weighted centroid accumulator: one request at a time. Accumulate steps
// through read, add and write back; finalize reads, then runs bit-serial
// restoring division (one divider per channel running in step) and waits for
// the output; clear zeroes one memory entry per cycle across all ENTRIES.
// After reset the same clearing pass runs before the first request is taken.
// The sums live in memories with one write port and one registered read port.
// Top level: joins wca_ctrl and wca_dpath; uses wca_pkg and assert_macros.svh.
`include "assert_macros.svh"
module weighted_centroid_accumulator_core import wca_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   wca_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .req_command(req_data.command),
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   wca_dpath u_dpath (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_data
   );

   `ASSERT_IMPL(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
   `ASSERT_IMPL(a_busy_no_load, clock, reset,
      req_stall |-> !cmd.load, "request captured while busy")
   `ASSERT_ALWAYS(a_no_wr_clash, clock,
      !(cmd.clr_step && cmd.add_wr), "clear and accumulate write together")
endmodule

/* hdl/wca_ctrl.sv */
// Controller state machine of the weighted centroid accumulator.
// Depends on wca_pkg.
module wca_ctrl import wca_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic [1:0] req_command,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);
   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_READ  = 8'b00000100,
      ST_ADD   = 8'b00001000,
      ST_FREAD = 8'b00010000,
      ST_DIV   = 8'b00100000,
      ST_DONE  = 8'b01000000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Sequence one request
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (req_command)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_ACCUM: state_in = ST_READ;
                  CMD_FINAL: state_in = ST_FREAD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_wr = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FREAD: begin
            cmd.rd = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // first cycle of this state loads the dividers from read data
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* hdl/wca_dpath.sv */
// Datapath: sum memories, saturating accumulate and restoring dividers.
// Depends on wca_pkg.
module wca_dpath import wca_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);
   logic [SUM_W-1:0]  alpha_mem [ENTRIES];
   logic [SUM_W-1:0]  red_mem   [ENTRIES];
   logic [SUM_W-1:0]  green_mem [ENTRIES];
   logic [SUM_W-1:0]  blue_mem  [ENTRIES];
   logic [WSUM_W-1:0] wsum_mem  [ENTRIES];

   req_type req_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [SUM_W-1:0]  rd_sum_ff [4];
   logic [WSUM_W-1:0] rd_wsum_ff;
   logic [31:0] prod_ff [4];
   logic div_first_ff;
   logic [5:0] div_cnt_ff;
   logic [SUM_W-1:0]  num_ff [4];
   logic [WSUM_W:0]   rem_ff [4];
   logic [QUO_W-1:0]  quo_ff [4];
   logic [15:0] chan [4];
   logic [IDX_W-1:0] idx;
   logic in_range;
   rsp_type rsp_ff;

   assign idx = req_ff.entry[IDX_W-1:0];
   assign in_range = ({24'd0, req_ff.entry} < 32'(ENTRIES));
   assign sts.clr_last = (32'(clr_idx_ff) == ENTRIES - 1);
   assign sts.div_last = !div_first_ff && (div_cnt_ff == 6'(SUM_W - 1));
   assign rsp_data = rsp_ff;

   // Capture request; form registered products ahead of the add
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      prod_ff[0] <= req_ff.alpha_in * req_ff.weight;
      prod_ff[1] <= req_ff.red_in * req_ff.weight;
      prod_ff[2] <= req_ff.green_in * req_ff.weight;
      prod_ff[3] <= req_ff.blue_in * req_ff.weight;
   end

   // Clear sweep counter
   always_ff @(posedge clock) begin
      if (reset || !cmd.clr_step) clr_idx_ff <= '0;
      else clr_idx_ff <= clr_idx_ff + 1'b1;
   end

   // Memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      logic [SUM_W:0] s [4];
      logic [WSUM_W:0] ws;
      for (int i = 0; i < 4; i++)
         s[i] = {1'b0, rd_sum_ff[i]} + {17'd0, prod_ff[i]};
      ws = {1'b0, rd_wsum_ff} + {17'd0, req_ff.weight};
      if (cmd.clr_step) begin
         alpha_mem[clr_idx_ff] <= '0;
         red_mem[clr_idx_ff]   <= '0;
         green_mem[clr_idx_ff] <= '0;
         blue_mem[clr_idx_ff]  <= '0;
         wsum_mem[clr_idx_ff]  <= '0;
      end else if (cmd.add_wr && in_range) begin
         alpha_mem[idx] <= s[0][SUM_W] ? '1 : s[0][SUM_W-1:0];
         red_mem[idx]   <= s[1][SUM_W] ? '1 : s[1][SUM_W-1:0];
         green_mem[idx] <= s[2][SUM_W] ? '1 : s[2][SUM_W-1:0];
         blue_mem[idx]  <= s[3][SUM_W] ? '1 : s[3][SUM_W-1:0];
         wsum_mem[idx]  <= ws[WSUM_W] ? '1 : ws[WSUM_W-1:0];
      end
      if (cmd.rd) begin
         rd_sum_ff[0] <= alpha_mem[idx];
         rd_sum_ff[1] <= red_mem[idx];
         rd_sum_ff[2] <= green_mem[idx];
         rd_sum_ff[3] <= blue_mem[idx];
         rd_wsum_ff   <= wsum_mem[idx];
      end
   end

   // Restoring dividers, one quotient bit per cycle per channel
   always_ff @(posedge clock) begin
      logic [WSUM_W:0] trial;
      if (reset) begin
         div_first_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         div_first_ff <= cmd.rd;
         if (cmd.div_step && !div_first_ff) div_cnt_ff <= div_cnt_ff + 1'b1;
         else div_cnt_ff <= '0;
      end
      if (div_first_ff) begin
         for (int i = 0; i < 4; i++) begin
            num_ff[i] <= rd_sum_ff[i];
            rem_ff[i] <= '0;
            quo_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < 4; i++) begin
            trial = {rem_ff[i][WSUM_W-1:0], num_ff[i][SUM_W-1]};
            num_ff[i] <= {num_ff[i][SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, rd_wsum_ff}) begin
               rem_ff[i] <= trial - {1'b0, rd_wsum_ff};
               quo_ff[i] <= (quo_ff[i][QUO_W-1]) ? '1 : {quo_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial;
               quo_ff[i] <= (quo_ff[i][QUO_W-1]) ? '1 : {quo_ff[i][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // Clamp quotients and form the result
   always_comb begin
      for (int i = 0; i < 4; i++)
         chan[i] = quo_ff[i][QUO_W-1] ? 16'hFFFF : quo_ff[i][15:0];
   end

   always_ff @(posedge clock) begin
      logic live;
      live = in_range && (rd_wsum_ff != '0);
      if (cmd.rsp_load) begin
         rsp_ff.entry_out   <= req_ff.entry;
         rsp_ff.alpha_out   <= live ? chan[0] : '0;
         rsp_ff.red_out     <= live ? chan[1] : '0;
         rsp_ff.green_out   <= live ? chan[2] : '0;
         rsp_ff.blue_out    <= live ? chan[3] : '0;
         rsp_ff.popularity  <= live ? rd_wsum_ff : '0;
         rsp_ff.has_members <= live;
      end
   end
endmodule

/* dv/tb_weighted_centroid_accumulator_core.sv */
// Self-checking testbench for weighted_centroid_accumulator_core: directed
// and random requests, bursty sender, patterned receiver stalls, scoreboard.
// Depends on wca_pkg and the core RTL.
module tb_weighted_centroid_accumulator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import wca_pkg::*;

   localparam longint unsigned CHAN_SAT   = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned WEIGHT_SAT = 64'hFFFF_FFFF;
   localparam int              IDLE_LIMIT = 4000;
   localparam int              DRAIN      = 80;
   localparam logic [1:0]      CMD_UNUSED = 2'd3;

   // Keep per-entry weighted sums and the queue of expected finalize results.
   class centroid_scoreboard;
      longint unsigned chan_sum[4][ENTRIES];
      longint unsigned wt_sum[ENTRIES];
      rsp_type         expected_q[$];
      int              errors;

      function new();
         wipe();
         errors = 0;
      endfunction

      function void wipe();
         foreach (wt_sum[i]) begin
            wt_sum[i] = 0;
            for (int c = 0; c < 4; c++) chan_sum[c][i] = 0;
         end
      endfunction

      function logic [15:0] mean(longint unsigned s, longint unsigned t);
         longint unsigned q;
         q = s / t;
         return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      endfunction

      // Update the sums for one accepted request; queue a result on finalize.
      function void note_request(req_type r);
         longint unsigned chan[4];
         longint unsigned acc;
         rsp_type         e;
         chan = '{r.alpha_in, r.red_in, r.green_in, r.blue_in};
         case (r.command)
            CMD_CLEAR: wipe();
            CMD_ACCUM: begin
               if (r.entry < ENTRIES) begin
                  for (int c = 0; c < 4; c++) begin
                     acc = chan_sum[c][r.entry] + chan[c] * r.weight;
                     chan_sum[c][r.entry] = (acc > CHAN_SAT) ? CHAN_SAT : acc;
                  end
                  acc = wt_sum[r.entry] + r.weight;
                  wt_sum[r.entry] = (acc > WEIGHT_SAT) ? WEIGHT_SAT : acc;
               end
            end
            CMD_FINAL: begin
               e = '0;
               e.entry_out = r.entry;
               if (r.entry < ENTRIES && wt_sum[r.entry] != 0) begin
                  e.alpha_out   = mean(chan_sum[0][r.entry], wt_sum[r.entry]);
                  e.red_out     = mean(chan_sum[1][r.entry], wt_sum[r.entry]);
                  e.green_out   = mean(chan_sum[2][r.entry], wt_sum[r.entry]);
                  e.blue_out    = mean(chan_sum[3][r.entry], wt_sum[r.entry]);
                  e.popularity  = wt_sum[r.entry][31:0];
                  e.has_members = 1'b1;
               end
               expected_q.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void cmp(string field, longint unsigned e, longint unsigned a);
         if (e != a) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, field, e, a);
         end
      endfunction

      // Compare one accepted result against the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result expected none actual %h", $time, got);
            return;
         end
         e = expected_q.pop_front();
         cmp("entry_out", e.entry_out, got.entry_out);
         cmp("alpha_out", e.alpha_out, got.alpha_out);
         cmp("red_out", e.red_out, got.red_out);
         cmp("green_out", e.green_out, got.green_out);
         cmp("blue_out", e.blue_out, got.blue_out);
         cmp("popularity", e.popularity, got.popularity);
         cmp("has_members", e.has_members, got.has_members);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   centroid_scoreboard sb = new();
   int burst_left = 0;
   int stall_pct = 0;
   int idle_cycles = 0;
   bit no_gaps = 0;
   longint cycle_cnt = 0;

   weighted_centroid_accumulator_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request, hold it until accepted, then idle between bursts.
   task automatic send_request(req_type r);
      int gap;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic send_cmd(logic [1:0] cmd, logic [7:0] idx, logic [15:0] a,
                           logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] w);
      req_type q;
      q = '{command: cmd, entry: idx, alpha_in: a, red_in: r, green_in: g,
            blue_in: b, weight: w};
      send_request(q);
   endtask

   // Check results, vary the stall pattern, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt % 300 == 0) stall_pct <= $urandom_range(0, 3) * 25;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      logic [7:0] idx;
      int pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty entries, field extremes, zero weight, unused command.
      send_cmd(CMD_FINAL, 8'd0, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'd255, 0, 0, 0, 0, 0);
      send_cmd(CMD_ACCUM, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_ACCUM, 8'd255, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'h0);
      send_cmd(CMD_FINAL, 8'd0, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'd255, 0, 0, 0, 0, 0);
      send_cmd(CMD_ACCUM, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001);
      send_cmd(CMD_ACCUM, 8'hAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
      send_cmd(CMD_ACCUM, 8'h55, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA);
      send_cmd(CMD_ACCUM, 8'hAA, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h0100);
      send_cmd(CMD_UNUSED, 8'hAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_FINAL, 8'd255, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'hAA, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'h55, 0, 0, 0, 0, 0);
      send_cmd(CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(CMD_FINAL, 8'hAA, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'd0, 0, 0, 0, 0, 0);

      // Random: mostly accumulate into a working set, some finalize, rare clear or unused command.
      for (int n = 0; n < 1840; n++) begin
         pick = $urandom_range(0, 99);
         idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 7));
         if (pick < 1)
            send_cmd(CMD_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
         else if (pick < 3)
            send_cmd(CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
         else if (pick < 15)
            send_cmd(CMD_FINAL, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
         else
            send_cmd(CMD_ACCUM, idx, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)),
                     ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 511))
                                                 : 16'($urandom_range(0, 65535)));
      end

      // Accumulate into one entry back to back.
      send_cmd(CMD_CLEAR, 8'd0, 0, 0, 0, 0, 0);
      send_cmd(CMD_ACCUM, 8'd4, 16'h1234, 16'h8000, 16'h0001, 16'hFFFF, 16'h0300);
      no_gaps = 1;
      for (int n = 0; n < 40; n++)
         send_cmd(CMD_ACCUM, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      no_gaps = 0;
      send_cmd(CMD_FINAL, 8'd3, 0, 0, 0, 0, 0);
      send_cmd(CMD_ACCUM, 8'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001);
      send_cmd(CMD_FINAL, 8'd3, 0, 0, 0, 0, 0);
      send_cmd(CMD_FINAL, 8'd4, 0, 0, 0, 0, 0);

      // Drain outstanding results, then allow for trailing latency.
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
